>>> src/gwws_pkg.sv
// ----------------------------------------------------------------------------
// gwws_pkg: shared types, constants and helpers for the word wrap stream
// Line store geometry, character codes and column arithmetic.
// ----------------------------------------------------------------------------
package gwws_pkg;

	localparam int LINE_CAP = 32;
	localparam int TAB_STOP = 8;
	localparam int ADDR_W   = $clog2(LINE_CAP);
	localparam int CNT_W    = $clog2(LINE_CAP + 1);
	localparam int COL_W    = 7;
	localparam int WIDTH_W  = 6;
	localparam int CHAR_W   = 8;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [COL_W-1:0]   col_t;
	typedef logic [WIDTH_W-1:0] width_t;
	typedef logic [CHAR_W-1:0]  char_t;

	localparam col_t   COL_MAX     = 7'd127;
	localparam width_t WIDTH_RESET = 6'd32;

	localparam char_t CH_NL  = 8'd10;
	localparam char_t CH_SP  = 8'd32;
	localparam char_t CH_TAB = 8'd9;

	// advance one column, saturating
	function automatic col_t col_inc(col_t col);
		if (col == COL_MAX) begin
			return COL_MAX;
		end
		return col + col_t'(1);
	endfunction

	// advance to the next tab stop, saturating
	function automatic col_t tab_next(col_t col);
		int tmp;
		tmp = (int'(col) / TAB_STOP + 1) * TAB_STOP;
		if (tmp > int'(COL_MAX)) begin
			return COL_MAX;
		end
		return col_t'(tmp);
	endfunction

	// clamp the programmed width to the store capacity
	function automatic cnt_t limit_width(width_t w);
		if (int'(w) > LINE_CAP) begin
			return cnt_t'(LINE_CAP);
		end
		return cnt_t'(w);
	endfunction

endpackage

>>> src/gwws_ifs.sv
// ----------------------------------------------------------------------------
// gwws_ifs: valid/ready channels of the word wrap stream
// Input item channel, result channel and width register write channel.
// ----------------------------------------------------------------------------
interface gwws_in_if;
	logic                  valid;
	logic                  ready;
	logic                  kind;
	gwws_pkg::char_t       char_in;

	modport source (output valid, output kind, output char_in, input ready);
	modport sink   (input valid, input kind, input char_in, output ready);
endinterface

interface gwws_out_if;
	logic                  valid;
	logic                  ready;
	gwws_pkg::char_t       out_char;
	logic                  last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink   (input valid, input out_char, input last, output ready);
endinterface

interface gwws_cfg_if;
	logic                  valid;
	logic                  ready;
	gwws_pkg::width_t      max_width;

	modport source (output valid, output max_width, input ready);
	modport sink   (input valid, input max_width, output ready);
endinterface

>>> src/gwws_ram.sv
// ----------------------------------------------------------------------------
// gwws_ram: generic single write port, single read port RAM
// Registered read data, held while no read is issued.
// ----------------------------------------------------------------------------
module gwws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/gwws_seq.sv
// ----------------------------------------------------------------------------
// gwws_seq: line store sequencer of the word wrap stream
// Plans each item on accept, then moves, emits, breaks and stores one
// line store entry at a time through a shared index unit.
// ----------------------------------------------------------------------------
module gwws_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  gwws_pkg::cnt_t    wrap_width,
	gwws_in_if.sink           din,
	gwws_out_if.source        dout
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_NL,
		ST_STORE
	} state_t;

	state_t            state_q;
	gwws_pkg::col_t    col_q;
	gwws_pkg::cnt_t    fill_q;
	gwws_pkg::cnt_t    ws_q;
	logic              in_word_q;
	gwws_pkg::cnt_t    idx_q;
	gwws_pkg::cnt_t    cnt_q;
	gwws_pkg::cnt_t    src_q;
	logic              nl_q;
	logic              store_q;
	gwws_pkg::addr_t   st_addr_q;
	gwws_pkg::char_t   st_char_q;
	logic              out_valid_q;
	gwws_pkg::char_t   out_char_q;
	logic              out_last_q;

	// plan of the item at the input
	gwws_pkg::cnt_t    p_emit_n;
	gwws_pkg::cnt_t    p_move_len;
	logic              p_nl;
	logic              p_store;
	gwws_pkg::addr_t   p_addr;
	gwws_pkg::col_t    n_col;
	gwws_pkg::cnt_t    n_fill;
	gwws_pkg::cnt_t    n_ws;
	logic              n_iw;
	state_t            p_next;

	gwws_pkg::col_t    w_col;
	gwws_pkg::char_t   ch;
	logic              is_ws;
	logic              slot_free;
	logic              out_load;
	gwws_pkg::cnt_t    idx_inc;
	logic              idx_end;
	state_t            after_emit;

	logic              ram_we;
	gwws_pkg::addr_t   ram_waddr;
	gwws_pkg::char_t   ram_wdata;
	logic              ram_re;
	gwws_pkg::addr_t   ram_raddr;
	gwws_pkg::char_t   ram_rdata;

	assign w_col     = gwws_pkg::col_t'(wrap_width);
	assign ch        = din.char_in;
	assign is_ws     = (ch == gwws_pkg::CH_SP) || (ch == gwws_pkg::CH_TAB);
	assign slot_free = !out_valid_q || dout.ready;
	assign out_load  = ((state_q == ST_EMIT_WR) || (state_q == ST_NL)) && slot_free;
	assign idx_inc   = idx_q + gwws_pkg::cnt_t'(1);
	assign idx_end   = (idx_inc == cnt_q);

	assign din.ready     = (state_q == ST_IDLE);
	assign dout.valid    = out_valid_q;
	assign dout.out_char = out_char_q;
	assign dout.last     = out_last_q;

	always_comb begin
		gwws_pkg::cnt_t f1;
		gwws_pkg::cnt_t s1;
		gwws_pkg::col_t c1;
		logic           iw1;
		gwws_pkg::cnt_t len;

		p_emit_n   = '0;
		p_move_len = '0;
		p_nl       = 1'b0;
		p_store    = 1'b0;
		p_addr     = '0;
		n_col      = col_q;
		n_fill     = fill_q;
		n_ws       = ws_q;
		n_iw       = in_word_q;
		f1         = fill_q;
		s1         = ws_q;
		c1         = col_q;
		iw1        = in_word_q;
		len        = '0;

		if (din.kind) begin
			p_emit_n = fill_q;
			n_fill   = '0;
			n_ws     = '0;
			n_iw     = 1'b0;
		end else if (ch == gwws_pkg::CH_NL) begin
			// trailing whitespace is dropped unless a word is open
			p_emit_n = in_word_q ? fill_q : '0;
			n_fill   = '0;
			n_ws     = '0;
			n_iw     = 1'b0;
			n_col    = '0;
			p_nl     = 1'b1;
		end else if (is_ws) begin
			if (in_word_q) begin
				p_emit_n = fill_q;
				f1       = '0;
				s1       = '0;
			end
			c1     = (ch == gwws_pkg::CH_SP) ? gwws_pkg::col_inc(col_q)
			                                 : gwws_pkg::tab_next(col_q);
			n_iw   = 1'b0;
			n_col  = c1;
			n_ws   = s1;
			n_fill = f1;
			// keep whitespace only while it fits
			if (c1 <= w_col && f1 < gwws_pkg::cnt_t'(gwws_pkg::LINE_CAP)) begin
				p_store = 1'b1;
				p_addr  = f1[gwws_pkg::ADDR_W-1:0];
				n_fill  = f1 + gwws_pkg::cnt_t'(1);
			end
		end else begin
			if (col_q >= w_col) begin
				p_nl = 1'b1;
				if (!in_word_q) begin
					f1 = '0;
					s1 = '0;
					c1 = '0;
				end else if (ws_q == '0) begin
					// word spans the whole line: hard break
					p_emit_n = fill_q;
					f1       = '0;
					s1       = '0;
					iw1      = 1'b0;
					c1       = '0;
				end else begin
					// soft break: pull the word to the front
					len        = (fill_q > ws_q) ? fill_q - ws_q : '0;
					p_move_len = len;
					f1         = len;
					s1         = '0;
					c1         = gwws_pkg::col_t'(len);
				end
			end
			if (!iw1) begin
				s1 = f1;
			end
			n_iw   = 1'b1;
			n_ws   = s1;
			n_col  = gwws_pkg::col_inc(c1);
			n_fill = f1;
			if (f1 < gwws_pkg::cnt_t'(gwws_pkg::LINE_CAP)) begin
				p_store = 1'b1;
				p_addr  = f1[gwws_pkg::ADDR_W-1:0];
				n_fill  = f1 + gwws_pkg::cnt_t'(1);
			end
		end

		if (p_move_len != '0) begin
			p_next = ST_MOVE_RD;
		end else if (p_emit_n != '0) begin
			p_next = ST_EMIT_RD;
		end else if (p_nl) begin
			p_next = ST_NL;
		end else if (p_store) begin
			p_next = ST_STORE;
		end else begin
			p_next = ST_IDLE;
		end
	end

	always_comb begin
		if (nl_q) begin
			after_emit = ST_NL;
		end else if (store_q) begin
			after_emit = ST_STORE;
		end else begin
			after_emit = ST_IDLE;
		end
	end

	// shared index unit: base plus running index addresses the store
	always_comb begin
		gwws_pkg::cnt_t rd_idx;
		rd_idx    = (state_q == ST_MOVE_RD) ? src_q + idx_q : idx_q;
		ram_re    = (state_q == ST_MOVE_RD) || (state_q == ST_EMIT_RD);
		ram_raddr = rd_idx[gwws_pkg::ADDR_W-1:0];
		ram_we    = (state_q == ST_MOVE_WR) || (state_q == ST_STORE);
		ram_waddr = (state_q == ST_MOVE_WR) ? idx_q[gwws_pkg::ADDR_W-1:0] : st_addr_q;
		ram_wdata = (state_q == ST_MOVE_WR) ? ram_rdata : st_char_q;
	end

	gwws_ram #(
		.WIDTH (gwws_pkg::CHAR_W),
		.DEPTH (gwws_pkg::LINE_CAP)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			fill_q      <= '0;
			ws_q        <= '0;
			in_word_q   <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			src_q       <= '0;
			nl_q        <= 1'b0;
			store_q     <= 1'b0;
			st_addr_q   <= '0;
			st_char_q   <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						col_q     <= n_col;
						fill_q    <= n_fill;
						ws_q      <= n_ws;
						in_word_q <= n_iw;
						idx_q     <= '0;
						cnt_q     <= (p_move_len != '0) ? p_move_len : p_emit_n;
						src_q     <= ws_q;
						nl_q      <= p_nl;
						store_q   <= p_store;
						st_addr_q <= p_addr;
						st_char_q <= ch;
						state_q   <= p_next;
					end
				end
				ST_MOVE_RD: begin
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: begin
					idx_q   <= idx_inc;
					state_q <= idx_end ? ST_NL : ST_MOVE_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					// hold the read data until the output slot frees up
					if (slot_free) begin
						out_char_q  <= ram_rdata;
						out_last_q  <= idx_end && !nl_q;
						idx_q       <= idx_inc;
						state_q     <= idx_end ? after_emit : ST_EMIT_RD;
					end
				end
				ST_NL: begin
					if (slot_free) begin
						out_char_q  <= gwws_pkg::CH_NL;
						out_last_q  <= 1'b1;
						state_q     <= store_q ? ST_STORE : ST_IDLE;
					end
				end
				ST_STORE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= gwws_pkg::cnt_t'(gwws_pkg::LINE_CAP))
		else $error("line store fill past capacity");

	a_word_start: assert property (@(posedge clk) disable iff (!arst_n)
		ws_q <= fill_q)
		else $error("word start beyond fill index");

	a_move_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE_RD) |-> (int'(src_q) + int'(idx_q) < gwws_pkg::LINE_CAP))
		else $error("word move reads past the line store");

	a_break_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE_WR) && idx_end |=> (state_q == ST_NL))
		else $error("soft break finished without a newline");

endmodule

>>> src/greedy_word_wrap_stream_top.sv
// Steps: a plain character is accepted, then written to the line store; a
// line emission reads then outputs each byte, a soft break reads then writes
// each moved byte, a newline is output from its own state. The single line
// store read port serializes these steps. A new item is taken only in idle.
// Reset: column, fill, word state cleared, width 32; store contents kept.
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream_top: greedy word wrap over a byte stream
// Holds the wrap width register and drives the line store sequencer.
// ----------------------------------------------------------------------------
module greedy_word_wrap_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	gwws_in_if.sink     din,
	gwws_out_if.source  dout,
	gwws_cfg_if.sink    cfg
);

	gwws_pkg::width_t max_width_q;
	gwws_pkg::cnt_t   wrap_width;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= gwws_pkg::WIDTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			max_width_q <= cfg.max_width;
		end
	end

	// clamp to the store capacity
	assign wrap_width = gwws_pkg::limit_width(max_width_q);

	gwws_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wrap_width (wrap_width),
		.din        (din),
		.dout       (dout)
	);

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the greedy word wrap stream
// Streams text and flush items at several wrap widths and handshake loads.
// A line store model predicts every output byte, and the bench compares
// each one in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 100;
	localparam int ERR_SHOWN     = 10;

	typedef struct packed {
		logic            kind;
		gwws_pkg::char_t ch;
	} text_item_t;

	typedef struct packed {
		gwws_pkg::char_t ch;
		logic            last;
	} wrap_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	gwws_in_if  din_if ();
	gwws_out_if dout_if ();
	gwws_cfg_if cfg_if ();

	greedy_word_wrap_stream_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	always #10 clk = ~clk;

	// stimulus and expectation stores
	text_item_t      text_q[$];
	wrap_byte_t      wrapped_q[$];
	gwws_pkg::char_t step_q[$];

	// wrap model state
	gwws_pkg::char_t  line_buf [gwws_pkg::LINE_CAP];
	gwws_pkg::col_t   col;
	int               fill;
	int               wstart;
	bit               in_word;
	gwws_pkg::width_t width_reg;

	int  in_idle_pct;
	int  out_stall_pct;
	bit  in_took;
	int  n_queued;
	int  n_items;
	int  n_bytes;
	int  n_widths;
	int  n_errors;

	function automatic void log_mismatch(string msg);
		n_errors++;
		if (n_errors <= ERR_SHOWN) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void hold_byte(gwws_pkg::char_t c);
		if (fill < gwws_pkg::LINE_CAP) begin
			line_buf[fill] = c;
			fill++;
		end
	endfunction

	function automatic void emit_held();
		for (int i = 0; i < fill && i < gwws_pkg::LINE_CAP; i++) begin
			step_q.push_back(line_buf[i]);
		end
		fill = 0;
		wstart = 0;
		in_word = 1'b0;
	endfunction

	function automatic void wrap_predict(logic kind, gwws_pkg::char_t c);
		int lim;
		int nxt;
		int len;
		wrap_byte_t r;
		lim = (int'(width_reg) > gwws_pkg::LINE_CAP) ? gwws_pkg::LINE_CAP : int'(width_reg);
		step_q.delete();
		if (kind) begin
			emit_held();
		end else if (c == gwws_pkg::CH_NL) begin
			// drop trailing whitespace
			if (!in_word) begin
				fill = 0;
			end
			emit_held();
			col = '0;
			step_q.push_back(gwws_pkg::CH_NL);
		end else if (c == gwws_pkg::CH_SP || c == gwws_pkg::CH_TAB) begin
			if (in_word) begin
				emit_held();
			end
			nxt = (c == gwws_pkg::CH_SP) ? int'(col) + 1
			                             : (int'(col) / gwws_pkg::TAB_STOP + 1) * gwws_pkg::TAB_STOP;
			col = (nxt > int'(gwws_pkg::COL_MAX)) ? gwws_pkg::COL_MAX : gwws_pkg::col_t'(nxt);
			// hold whitespace only while it fits
			if (int'(col) <= lim) begin
				hold_byte(c);
			end
		end else begin
			if (int'(col) >= lim) begin
				if (!in_word) begin
					fill = 0;
					wstart = 0;
					col = '0;
				end else if (wstart == 0) begin
					emit_held();
					col = '0;
				end else begin
					// move the word to the front, drop the whitespace ahead of it
					len = (fill > wstart) ? fill - wstart : 0;
					for (int i = 0; i < len; i++) begin
						line_buf[i] = line_buf[wstart + i];
					end
					fill = len;
					wstart = 0;
					col = gwws_pkg::col_t'(len);
				end
				step_q.push_back(gwws_pkg::CH_NL);
			end
			if (!in_word) begin
				in_word = 1'b1;
				wstart = fill;
			end
			col = (col == gwws_pkg::COL_MAX) ? gwws_pkg::COL_MAX : col + gwws_pkg::col_t'(1);
			hold_byte(c);
		end
		foreach (step_q[i]) begin
			r.ch = step_q[i];
			r.last = (i == step_q.size() - 1);
			wrapped_q.push_back(r);
		end
	endfunction

	// driver: present the next pending item once the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			din_if.valid <= 1'b0;
		end else if (!din_if.valid || in_took) begin
			if (text_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
				din_if.valid <= 1'b1;
				din_if.kind <= text_q[0].kind;
				din_if.char_in <= text_q[0].ch;
				void'(text_q.pop_front());
			end else begin
				din_if.valid <= 1'b0;
				din_if.kind <= 1'($urandom_range(1));
				din_if.char_in <= gwws_pkg::char_t'($urandom_range(255));
			end
		end
	end

	always @(negedge clk) begin
		dout_if.ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// monitor: predict on accepted input, check each accepted output byte
	always @(posedge clk) begin : sample
		wrap_byte_t want;
		in_took <= arst_n && din_if.valid && din_if.ready;
		if (arst_n) begin
			if (din_if.valid && din_if.ready) begin
				n_items++;
				wrap_predict(din_if.kind, din_if.char_in);
			end
			if (dout_if.valid && dout_if.ready) begin
				n_bytes++;
				if (wrapped_q.size() == 0) begin
					log_mismatch($sformatf("unexpected byte: char %0d last %0b",
						dout_if.out_char, dout_if.last));
				end else begin
					want = wrapped_q.pop_front();
					if (dout_if.out_char !== want.ch || dout_if.last !== want.last) begin
						log_mismatch($sformatf(
							"byte %0d: expected char %0d last %0b, got char %0d last %0b",
							n_bytes, want.ch, want.last, dout_if.out_char, dout_if.last));
					end
				end
			end
		end
	end

	task automatic queue_item(logic kind, gwws_pkg::char_t c);
		text_item_t it;
		it.kind = kind;
		it.ch = c;
		text_q.push_back(it);
		n_queued++;
	endtask

	task automatic write_width(gwws_pkg::width_t w);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.max_width <= w;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		width_reg = w;
		n_widths++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// hold until every item is taken and every byte has come, then let the
	// block finish any silent work
	task automatic wait_drained();
		while (text_q.size() > 0 || din_if.valid || wrapped_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// queue exactly n items; the last run is cut short at the target
	task automatic gen_text(int n);
		int target;
		int len;
		int roll;
		gwws_pkg::char_t c;
		target = n_queued + n;
		while (n_queued < target) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				// a word, sometimes longer than a line, then whitespace
				len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
				for (int k = 0; k < len && n_queued < target; k++) begin
					do begin
						c = gwws_pkg::char_t'($urandom_range(255));
					end while (c == gwws_pkg::CH_NL || c == gwws_pkg::CH_SP ||
						c == gwws_pkg::CH_TAB);
					queue_item(1'b0, c);
				end
				repeat ($urandom_range(1, 3)) begin
					if (n_queued < target) begin
						queue_item(1'b0, $urandom_range(1) ? gwws_pkg::CH_SP : gwws_pkg::CH_TAB);
					end
				end
			end else if (roll < 80) begin
				queue_item(1'b0, gwws_pkg::CH_NL);
			end else if (roll < 86) begin
				queue_item(1'b1, gwws_pkg::char_t'($urandom_range(255)));
			end else if (roll < 90) begin
				// tab run long enough to saturate the column
				repeat (17) begin
					if (n_queued < target) begin
						queue_item(1'b0, gwws_pkg::CH_TAB);
					end
				end
			end else begin
				queue_item(1'($urandom_range(1)), gwws_pkg::char_t'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		gwws_pkg::width_t w;
		din_if.valid = 1'b0;
		din_if.kind = 1'b0;
		din_if.char_in = '0;
		dout_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.max_width = '0;
		col = '0;
		fill = 0;
		wstart = 0;
		in_word = 1'b0;
		width_reg = gwws_pkg::WIDTH_RESET;
		in_idle_pct = 0;
		out_stall_pct = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// width above the store capacity; byte extremes, flushes, whitespace
		write_width(6'd63);
		queue_item(1'b1, 8'h00);
		queue_item(1'b0, 8'h00);
		queue_item(1'b0, 8'hFF);
		queue_item(1'b0, gwws_pkg::CH_SP);
		queue_item(1'b0, gwws_pkg::CH_TAB);
		queue_item(1'b0, 8'h78);
		queue_item(1'b0, gwws_pkg::CH_NL);
		queue_item(1'b0, gwws_pkg::CH_SP);
		queue_item(1'b0, gwws_pkg::CH_SP);
		queue_item(1'b0, gwws_pkg::CH_NL);
		queue_item(1'b1, 8'hFF);
		queue_item(1'b0, 8'h77);
		queue_item(1'b1, 8'h00);
		wait_drained();

		// zero width: every word character breaks
		write_width(6'd0);
		queue_item(1'b0, 8'h61);
		queue_item(1'b0, 8'h62);
		queue_item(1'b0, gwws_pkg::CH_SP);
		queue_item(1'b0, 8'h63);
		queue_item(1'b0, gwws_pkg::CH_NL);
		wait_drained();

		// soft break on "ab cd", then "cdef" fills the line without a break
		write_width(6'd4);
		queue_item(1'b0, 8'h61);
		queue_item(1'b0, 8'h62);
		queue_item(1'b0, gwws_pkg::CH_SP);
		queue_item(1'b0, 8'h63);
		queue_item(1'b0, 8'h64);
		queue_item(1'b0, 8'h65);
		queue_item(1'b0, 8'h66);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_idle_pct = 85;
					out_stall_pct = 0;
				end
				2: begin
					in_idle_pct = 0;
					out_stall_pct = 85;
				end
				default: begin
					in_idle_pct = 33;
					out_stall_pct = 33;
				end
			endcase
			case (p)
				0: w = 6'd32;
				1: w = 6'd1;
				3: w = 6'd8;
				5: w = 6'd32;
				default: w = gwws_pkg::width_t'($urandom_range(2, 31));
			endcase
			write_width(w);
			if (p == 1) begin
				// pause the sender until the output side has drained
				gen_text(15);
				wait_drained();
				gen_text(16);
			end else begin
				gen_text(31);
			end
			wait_drained();
		end

		if (wrapped_q.size() != 0) begin
			log_mismatch($sformatf("%0d expected bytes never arrived", wrapped_q.size()));
		end
		$display("covered %0d input items and %0d output bytes over %0d width settings",
			n_items, n_bytes, n_widths);
		$display("handshake loads: none, sender idle, receiver stall, both; %0d mismatches",
			n_errors);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d items pending and %0d bytes expected",
			text_q.size(), wrapped_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
